FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the substring occurrence counter.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define SOC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SOC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SOC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/soc_pkg.sv
// Package of the substring occurrence counter: defaults, register codes,
// cell control struct and the pattern byte helper. No dependencies.
package soc_pkg;

   localparam int MAX_WORD_BYTES_DEF = 8;
   localparam int INDEX_BITS_DEF     = 16;
   localparam int PATTERN_BITS       = 64;
   localparam int PATTERN_BYTES      = PATTERN_BITS / 8;
   localparam int COUNT_BITS         = 16;
   localparam int LIMIT_BITS         = 16;
   localparam int WLEN_BITS          = 4;
   localparam int CFG_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 64;
   localparam logic [LIMIT_BITS-1:0] END_WHOLE = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CFG_PATTERN     = 2'd0,
      CFG_WORD_LENGTH = 2'd1,
      CFG_START_INDEX = 2'd2,
      CFG_END_LIMIT   = 2'd3
   } cfg_index_type;

   typedef struct packed {
      logic shift;   // a byte transfer moves the window
      logic clear;   // last byte: window empties for the next string
      logic active;  // this cell lies inside the word length
   } cell_ctrl_type;

   // Byte j of the pattern; bytes past the pattern register compare as zero.
   function automatic logic [7:0] soc_word_byte(input logic [PATTERN_BITS-1:0] pat,
                                                input logic [5:0] j);
      logic [7:0] result;
      if (j >= 6'(PATTERN_BYTES)) begin
         result = 8'd0;
      end else begin
         result = pat[{j[2:0], 3'b000} +: 8];
      end
      return result;
   endfunction

endpackage

FILE: rtl/soc_cell.sv
// One window cell of the substring occurrence counter: holds a byte, hands it on
// to its neighbor and compares the incoming byte with its pattern byte. Uses soc_pkg.
module soc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  soc_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             prev_byte,
   input  logic [7:0]             pattern_byte,
   output logic [7:0]             stored_byte,
   output logic                   byte_match
);
   import soc_pkg::*;

   logic [7:0] window_ff;
   logic [7:0] window_in;

   always_comb begin
      window_in = window_ff;
      if (ctrl.shift) begin
         window_in = ctrl.clear ? 8'd0 : prev_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 8'd0;
      end else begin
         window_ff <= window_in;
      end
   end

   // Compare the byte entering this cell; cells past the word always agree.
   assign byte_match  = !ctrl.active || (prev_byte == pattern_byte);
   assign stored_byte = window_ff;

endmodule

FILE: rtl/substring_occurrence_counter.sv
// Substring occurrence counter: counts non-overlapping matches of a word of up to
// MAX_WORD_BYTES bytes in a byte stream, greedy leftmost.
//
// Input channel req_: one string byte per transfer, req_tlast on the final byte.
// Result channel rsp_: one transfer per string carrying the match count.
// Configuration port csr_: write pattern, word length, start index and end limit
// while the block is idle; writes take effect at the next clock edge.
//
// Throughput: one byte per cycle while req_tready is high. A row of window
// cells shifts the bytes along and each compares the byte it takes in, so the
// match decision and counter update complete in the cycle a byte is accepted.
// Latency: the count appears on rsp_ in the cycle after the last byte is taken.
// A finished count waits in the output register. While it waits and the receiver
// holds rsp_tready low, req_ stalls on every byte (req_tready = output register
// empty or being drained), so no count is overwritten before it is taken.
// Reset (synchronous, active high) restores the register defaults, empties the
// window, and clears index, match bound, count and the output valid flag.
// Depends on soc_pkg, soc_cell and assert_macros.svh.
module substring_occurrence_counter #(
   parameter int MAX_WORD_BYTES = soc_pkg::MAX_WORD_BYTES_DEF,
   parameter int INDEX_BITS     = soc_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // last_byte
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [soc_pkg::COUNT_BITS-1:0]      rsp_tdata,   // [15:0] match_count
   // configuration write port
   input  logic                                csr_we,
   input  logic [soc_pkg::CFG_INDEX_BITS-1:0]  csr_index,
   input  logic [soc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import soc_pkg::*;
   `include "assert_macros.svh"

   // Compare width covers the match start, next allowed start and 16-bit limits.
   localparam int CW    = (INDEX_BITS + 1 > LIMIT_BITS + 1) ? INDEX_BITS + 1 : LIMIT_BITS + 1;
   localparam int LEN_W = ($clog2(MAX_WORD_BYTES + 1) > WLEN_BITS) ?
                          $clog2(MAX_WORD_BYTES + 1) : WLEN_BITS;

   // configuration registers
   logic [PATTERN_BITS-1:0] pattern_ff;
   logic [WLEN_BITS-1:0]    word_length_ff;
   logic [LIMIT_BITS-1:0]   start_index_ff;
   logic [LIMIT_BITS-1:0]   end_limit_ff;

   // per-string state
   logic [INDEX_BITS-1:0]   byte_index_ff, byte_index_in;
   logic [INDEX_BITS:0]     next_start_ff, next_start_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                    req_xfer;
   logic [LEN_W-1:0]        len_eff;
   logic [7:0]              cell_feed   [MAX_WORD_BYTES];
   logic [7:0]              cell_byte   [MAX_WORD_BYTES];
   logic [MAX_WORD_BYTES-1:0] cell_match;
   logic [CW-1:0]           end_pos;     // i + 1
   logic [CW-1:0]           match_start; // i + 1 - len
   logic                    word_hit;
   logic                    counted;

   // Hold off only when a new count would overwrite one not yet taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // Clamp the word length to the window depth.
   assign len_eff = (LEN_W'(word_length_ff) > LEN_W'(MAX_WORD_BYTES)) ?
                    LEN_W'(MAX_WORD_BYTES) : LEN_W'(word_length_ff);

   // Window cells: cell 0 takes the new byte, cell k the byte of cell k-1.
   // Cell k lines up with pattern byte len-1-k.
   for (genvar k = 0; k < MAX_WORD_BYTES; k++) begin : g_cell
      cell_ctrl_type ctrl;
      logic [5:0]    pat_sel;

      if (k == 0) begin : g_head
         assign cell_feed[k] = req_tdata;
      end else begin : g_body
         assign cell_feed[k] = cell_byte[k-1];
      end

      assign pat_sel     = 6'(len_eff) - 6'(k) - 6'd1;
      assign ctrl.shift  = req_xfer;
      assign ctrl.clear  = req_tlast;
      assign ctrl.active = (LEN_W'(k) < len_eff);

      soc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .prev_byte    (cell_feed[k]),
         .pattern_byte (soc_word_byte(pattern_ff, pat_sel)),
         .stored_byte  (cell_byte[k]),
         .byte_match   (cell_match[k])
      );
   end

   // Match decision for the word ending on the byte being taken.
   always_comb begin
      end_pos     = CW'(byte_index_ff) + CW'(1);
      match_start = end_pos - CW'(len_eff);
      word_hit    = (len_eff != '0) && (end_pos >= CW'(len_eff)) && (&cell_match);
      counted     = word_hit
                    && (match_start >= CW'(start_index_ff))
                    && (match_start >= CW'(next_start_ff))
                    && ((end_limit_ff == END_WHOLE) || (match_start < CW'(end_limit_ff)));
   end

   // Advance the per-string state; drop it after the last byte.
   always_comb begin
      byte_index_in = byte_index_ff;
      next_start_in = next_start_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (req_xfer) begin
         if (counted) begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
            next_start_in = end_pos[INDEX_BITS:0];
         end
         if (byte_index_ff != '1) begin
            byte_index_in = byte_index_ff + INDEX_BITS'(1);
         end
         if (req_tlast) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = count_in;
            byte_index_in = '0;
            next_start_in = '0;
            count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         word_length_ff <= WLEN_BITS'(1);
         start_index_ff <= '0;
         end_limit_ff   <= END_WHOLE;
         byte_index_ff  <= '0;
         next_start_ff  <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (cfg_index_type'(csr_index))
               CFG_PATTERN:     pattern_ff     <= csr_wdata[PATTERN_BITS-1:0];
               CFG_WORD_LENGTH: word_length_ff <= csr_wdata[WLEN_BITS-1:0];
               CFG_START_INDEX: start_index_ff <= csr_wdata[LIMIT_BITS-1:0];
               CFG_END_LIMIT:   end_limit_ff   <= csr_wdata[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
         byte_index_ff <= byte_index_in;
         next_start_ff <= next_start_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload register: no reset needed.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The match bound never runs past the byte after the current index.
   `SOC_ASSERT(a_bound_le_index, clock, reset,
      next_start_ff <= ({1'b0, byte_index_ff} + (INDEX_BITS+1)'(1)),
      "next allowed start ahead of byte index")
   // Within a string the count never goes down.
   `SOC_ASSERT_NEXT(a_count_monotonic, clock, reset, req_xfer && !req_tlast,
      count_ff >= $past(count_ff), "match count decreased within a string")
   // The last byte leaves a clean state for the next string.
   `SOC_ASSERT_NEXT(a_clear_after_last, clock, reset, req_xfer && req_tlast,
      byte_index_ff == '0 && count_ff == '0 && next_start_ff == '0 && rsp_valid_ff,
      "string state not cleared after last byte")
   // A result only appears after a last byte transfer.
   `SOC_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(req_xfer && req_tlast), "result without a last byte")

endmodule

FILE: test/testbench.sv
// Self-checking testbench for substring_occurrence_counter: a directed stimulus list, then
// random strings built around the configured word.
// Depends on soc_pkg and the RTL of the block; reads no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import soc_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 4;        // count shows up in the cycle after the last byte
   localparam int QUIET_LIMIT  = 1000;     // far above any legal stall, gap or drain
   localparam int RANDOM_BYTES = 1250;
   localparam int WIN_DEPTH    = MAX_WORD_BYTES_DEF;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   // One line of the directed stimulus list.
   typedef struct packed {
      row_kind_type               kind;
      cfg_index_type              sel;
      logic [CSR_DATA_BITS-1:0]   value;   // register value, or the byte in [7:0]
      logic                       last;
      logic                       pinned;  // count below is typed in by hand
      logic [COUNT_BITS-1:0]      count;
   } step_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_STALLS, RX_COIN} rx_mode_type;

   // ---------------------------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [7:0]                  req_tdata  = '0;   // [7:0] data_byte
   logic                        req_tlast  = 1'b0; // last_byte
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [COUNT_BITS-1:0]       rsp_tdata;         // [15:0] match_count
   logic                        csr_we     = 1'b0;
   logic [CFG_INDEX_BITS-1:0]   csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata  = '0;

   // Hand-typed count that travels alongside the byte it belongs to.
   logic                        pin_valid  = 1'b0;
   logic [COUNT_BITS-1:0]       pin_count  = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   substring_occurrence_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Shadow of the block: registers and per-string search state
   // ---------------------------------------------------------------------------------------
   logic [PATTERN_BITS-1:0]     cfg_word;
   logic [WLEN_BITS-1:0]        cfg_len;
   logic [LIMIT_BITS-1:0]       cfg_start;
   logic [LIMIT_BITS-1:0]       cfg_end;

   logic [7:0]                  win [WIN_DEPTH];   // newest byte in entry 0
   logic [INDEX_BITS_DEF-1:0]   pos;               // index of the next byte
   logic [INDEX_BITS_DEF:0]     bound;             // one past the last counted match
   logic [COUNT_BITS-1:0]       tally;

   logic [COUNT_BITS-1:0]       pending_counts [$];

   int                          mismatches      = 0;
   int                          strings_checked = 0;
   int                          bytes_sent      = 0;
   int                          settings_used   = 0;
   logic [COUNT_BITS-1:0]       top_count       = '0;

   // Sender pacing
   int                          burst_left = 0;
   bit                          eager      = 1'b0;   // no gaps at all while set

   // Receiver pacing
   int                          rx_cycle = 0;
   int                          rx_stall = 0;
   rx_mode_type                 rx_mode  = RX_OPEN;

   // Advance the shadow by one byte; hand back the count when the byte closes a string.
   task automatic scan_byte(input logic [7:0] b, input logic last,
                            output bit produced, output logic [COUNT_BITS-1:0] tally_out);
      int span;
      int origin;
      bit hit;
      span = int'(cfg_len);
      if (span > WIN_DEPTH) span = WIN_DEPTH;
      for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = b;
      if (span > 0 && int'(pos) + 1 >= span) begin
         origin = int'(pos) + 1 - span;
         hit = 1'b1;
         // oldest byte of the candidate sits deepest in the window
         for (int j = 0; j < span; j++)
            if (win[span-1-j] != cfg_word[8*j +: 8]) hit = 1'b0;
         if (hit && origin >= int'(cfg_start) && origin >= int'(bound) &&
             (cfg_end == END_WHOLE || origin < int'(cfg_end))) begin
            if (tally != COUNT_MAX) tally++;
            bound = (INDEX_BITS_DEF+1)'(int'(pos) + 1);
         end
      end
      // hold the index at its ceiling on over-long strings
      if (pos != '1) pos++;
      produced  = last;
      tally_out = tally;
      if (last) begin
         foreach (win[k]) win[k] = '0;
         pos   = '0;
         bound = '0;
         tally = '0;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------------------------
   // Monitor: sample every transfer at the rising edge, predict on the way in, check on the
   // way out. Everything happens in one process so the order is fixed.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      bit                    produced;
      logic [COUNT_BITS-1:0] tally_now;
      logic [COUNT_BITS-1:0] want;
      if (reset) begin
         cfg_word  = '0;
         cfg_len   = WLEN_BITS'(1);
         cfg_start = '0;
         cfg_end   = END_WHOLE;
         foreach (win[k]) win[k] = '0;
         pos   = '0;
         bound = '0;
         tally = '0;
         pending_counts.delete();
      end else begin
         // bytes see the settings from before a write in the same cycle
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata, req_tlast, produced, tally_now);
            if (produced) pending_counts.push_back(pin_valid ? pin_count : tally_now);
         end
         if (csr_we) begin
            case (cfg_index_type'(csr_index))
               CFG_PATTERN:     cfg_word  = csr_wdata[PATTERN_BITS-1:0];
               CFG_WORD_LENGTH: cfg_len   = csr_wdata[WLEN_BITS-1:0];
               CFG_START_INDEX: cfg_start = csr_wdata[LIMIT_BITS-1:0];
               CFG_END_LIMIT:   cfg_end   = csr_wdata[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_counts.size() == 0) begin
               report_mismatch($sformatf("count %0d arrived with none outstanding",
                                         rsp_tdata));
            end else begin
               want = pending_counts.pop_front();
               strings_checked++;
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("match_count %0d, predicted %0d",
                                            rsp_tdata, want));
               else if (rsp_tdata > top_count)
                  top_count = rsp_tdata;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: pick a new mode at random from always ready, spotty, long stalls and coin flips
   // so stalls land on every phase of a string.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall--;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_SPOTTY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_STALLS: begin
               if ($urandom_range(0, 15) == 0) begin
                  rx_stall = $urandom_range(1, 20);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
            default:   rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: drop out when nothing has moved for too long.
   // ---------------------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Driving helpers
   // ---------------------------------------------------------------------------------------

   // Present one byte, inserting a random gap at the start of each burst, and hold it until
   // the transfer completes. Valid stays high on return so the next byte can follow directly.
   task automatic send_byte(input logic [7:0] data, input logic last, input logic pinned,
                            input logic [COUNT_BITS-1:0] count);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      csr_we     <= 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      pin_valid  <= pinned;
      pin_count  <= count;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   // Write one register; the caller lowers the enable with its next action.
   task automatic put_csr(input cfg_index_type sel, input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Stop sending, wait for every outstanding count, then let the block go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic step_row_type csr_row(input cfg_index_type sel,
                                            input logic [CSR_DATA_BITS-1:0] value);
      step_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.sel   = sel;
      r.value = value;
      return r;
   endfunction

   function automatic step_row_type text_byte(input logic [7:0] data);
      step_row_type r;
      r       = '0;
      r.kind  = ROW_BYTE;
      r.value = CSR_DATA_BITS'(data);
      return r;
   endfunction

   function automatic step_row_type closing_byte(input logic [7:0] data,
                                                 input logic [COUNT_BITS-1:0] count);
      step_row_type r;
      r        = text_byte(data);
      r.last   = 1'b1;
      r.pinned = 1'b1;
      r.count  = count;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      step_row_type             directed_rows [$];
      step_row_type             row;
      logic                     prev_csr;
      logic [PATTERN_BITS-1:0]  word;
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [LIMIT_BITS-1:0]    lim;
      logic [7:0]               sym_a;
      logic [7:0]               sym_b;
      logic [7:0]               text_q [$];
      int                       span;
      int                       pick;
      int                       cut;
      int                       text_len;
      int                       rand_bytes;

      // Reset defaults: word of one zero byte, whole string in range.
      directed_rows.push_back(closing_byte(8'h00, 16'd1));
      directed_rows.push_back(closing_byte(8'hFF, 16'd0));
      // "aba" in "ababa": the second hit overlaps the first and is skipped.
      directed_rows.push_back(csr_row(CFG_PATTERN, 64'h0000_0000_0061_6261));
      directed_rows.push_back(csr_row(CFG_WORD_LENGTH, 64'd3));
      directed_rows.push_back(text_byte(8'h61));
      directed_rows.push_back(text_byte(8'h62));
      directed_rows.push_back(text_byte(8'h61));
      directed_rows.push_back(text_byte(8'h62));
      directed_rows.push_back(closing_byte(8'h61, 16'd1));
      // Zero word length never matches.
      directed_rows.push_back(csr_row(CFG_WORD_LENGTH, 64'd0));
      directed_rows.push_back(closing_byte(8'h61, 16'd0));
      // Length 15 clamps to eight bytes; all-ones word.
      directed_rows.push_back(csr_row(CFG_PATTERN, '1));
      directed_rows.push_back(csr_row(CFG_WORD_LENGTH, 64'd15));
      repeat (7) directed_rows.push_back(text_byte(8'hFF));
      directed_rows.push_back(closing_byte(8'hFF, 16'd1));
      // Start index at its maximum shuts everything out.
      directed_rows.push_back(csr_row(CFG_WORD_LENGTH, 64'd1));
      directed_rows.push_back(csr_row(CFG_START_INDEX, 64'hFFFF));
      directed_rows.push_back(closing_byte(8'hFF, 16'd0));
      // End limit zero shuts everything out; end limit one lets only index zero in.
      directed_rows.push_back(csr_row(CFG_START_INDEX, 64'd0));
      directed_rows.push_back(csr_row(CFG_END_LIMIT, 64'd0));
      directed_rows.push_back(closing_byte(8'hFF, 16'd0));
      directed_rows.push_back(csr_row(CFG_END_LIMIT, 64'd1));
      directed_rows.push_back(text_byte(8'hFF));
      directed_rows.push_back(closing_byte(8'hFF, 16'd1));
      // Start index one skips only the first byte.
      directed_rows.push_back(csr_row(CFG_END_LIMIT, 64'hFFFF));
      directed_rows.push_back(csr_row(CFG_START_INDEX, 64'd1));
      directed_rows.push_back(text_byte(8'hFF));
      directed_rows.push_back(text_byte(8'hFF));
      directed_rows.push_back(closing_byte(8'hFF, 16'd2));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed list; quiesce before the first write of each group.
      prev_csr = 1'b0;
      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.kind == ROW_CSR) begin
            if (!prev_csr) settle();
            put_csr(row.sel, row.value);
            prev_csr = 1'b1;
         end else begin
            send_byte(row.value[7:0], row.last, row.pinned, row.count);
            prev_csr = 1'b0;
         end
      end
      settings_used += 5;

      // Random phases: fresh settings, then a handful of strings salted with the word.
      rand_bytes = 0;
      while (rand_bytes < RANDOM_BYTES) begin
         settle();
         sym_a = 8'($urandom_range(0, 255));
         sym_b = 8'($urandom_range(0, 255));

         // small alphabet for the word so overlaps and near misses are common
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            word = '0;
         end else if (pick == 1) begin
            word = '1;
         end else if (pick == 2) begin
            word = {$urandom, $urandom};
         end else begin
            for (int j = 0; j < PATTERN_BYTES; j++)
               word[8*j +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                ($urandom_range(0, 1) ? sym_a : sym_b);
         end
         put_csr(CFG_PATTERN, word);

         // stray upper bits on the narrow registers now and then
         pick = $urandom_range(0, 15);
         span = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
         wdata = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
         wdata[WLEN_BITS-1:0] = WLEN_BITS'(span);
         put_csr(CFG_WORD_LENGTH, wdata);

         pick = $urandom_range(0, 19);
         if (pick < 11)       lim = '0;
         else if (pick < 17)  lim = LIMIT_BITS'($urandom_range(1, 30));
         else if (pick == 17) lim = '1;
         else                 lim = LIMIT_BITS'($urandom_range(0, 65535));
         wdata = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
         wdata[LIMIT_BITS-1:0] = lim;
         put_csr(CFG_START_INDEX, wdata);

         pick = $urandom_range(0, 19);
         if (pick < 9)        lim = END_WHOLE;
         else if (pick < 16)  lim = LIMIT_BITS'($urandom_range(0, 40));
         else if (pick == 16) lim = '0;
         else if (pick == 17) lim = END_WHOLE - 1'b1;
         else                 lim = LIMIT_BITS'($urandom_range(0, 65535));
         wdata = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
         wdata[LIMIT_BITS-1:0] = lim;
         put_csr(CFG_END_LIMIT, wdata);
         settings_used++;

         eager = ($urandom_range(0, 3) == 0);
         if (span > WIN_DEPTH) span = WIN_DEPTH;
         if (span == 0) span = 1;

         repeat ($urandom_range(3, 10)) begin
            text_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 90)
                                                   : $urandom_range(1, 40);
            text_q.delete();
            while (text_q.size() < text_len) begin
               pick = $urandom_range(0, 19);
               if (pick < 9) begin
                  for (int j = 0; j < span; j++) text_q.push_back(word[8*j +: 8]);
               end else if (pick < 11) begin
                  // broken-off start of the word
                  cut = $urandom_range(1, span);
                  for (int j = 0; j < cut; j++) text_q.push_back(word[8*j +: 8]);
               end else if (pick < 17) begin
                  text_q.push_back($urandom_range(0, 1) ? sym_a : sym_b);
               end else begin
                  text_q.push_back(8'($urandom_range(0, 255)));
               end
            end
            while (text_q.size() > text_len) void'(text_q.pop_back());
            foreach (text_q[j]) send_byte(text_q[j], j == text_q.size() - 1, 1'b0, '0);
            rand_bytes += text_len;
         end
      end

      // Drain the tail and give any stray result a chance to show up.
      eager = 1'b0;
      settle();

      $display("Checked %0d strings, %0d bytes, under %0d register settings; top count %0d.",
               strings_checked, bytes_sent, settings_used, top_count);
      $display("Included overlap, clamped and zero word lengths, range limits, receiver stalls.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
